// ===== rtl/rgpc_pkg.sv =====
// ============================================================================
// rgpc_pkg: shared types, constants and helpers for ray grid plane crossings
// Holds the transaction structs, the controller command set, the axis
// rotation helpers and the coordinate saturation used by the datapath.
// ============================================================================
`default_nettype none

package rgpc_pkg;

   // Field widths fixed by the interface
   localparam int POS_W    = 24;
   localparam int DIR_W    = 16;
   localparam int DMAG_W   = 16;
   localparam int DSQ_W    = 32;
   localparam int SAT_W    = 64;
   localparam int RADIUS_W = 5;

   // Defaults for the top-level parameters
   localparam int MAX_RADIUS_DEF = 20;
   localparam int FRAC_BITS_DEF  = 12;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd8;

   // Axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic signed [POS_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 24'sh7FFFFF;
   localparam coord_type COORD_MIN = -24'sh800000;

   typedef struct packed {
      coord_type                 pos_x;
      coord_type                 pos_y;
      coord_type                 pos_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
   } req_type;

   typedef struct packed {
      coord_type   hit_x;
      coord_type   hit_y;
      coord_type   hit_z;
      logic [1:0]  plane_axis;
      logic        last_hit;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ,
      OP_LIM,
      OP_LIM2,
      OP_DK2,
      OP_ML,
      OP_MH,
      OP_CMP,
      OP_SELM,
      OP_SELC,
      OP_NUM,
      OP_DIVGO,
      OP_ADV,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        use_best;
      logic [1:0]  ax;
   } cmd_type;

   typedef struct packed {
      logic any_valid;
      logic div_done;
      logic out_free;
   } stat_type;

   // Next axis in x, y, z rotation
   function automatic logic [1:0] next_axis(input logic [1:0] a);
      logic [1:0] r;
      case (a)
         AXIS_X:  r = AXIS_Y;
         AXIS_Y:  r = AXIS_Z;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

   // Previous axis in x, y, z rotation
   function automatic logic [1:0] prev_axis(input logic [1:0] a);
      logic [1:0] r;
      case (a)
         AXIS_X:  r = AXIS_Z;
         AXIS_Y:  r = AXIS_X;
         default: r = AXIS_Y;
      endcase
      return r;
   endfunction

   // Clamp a wide signed value to the coordinate range
   function automatic coord_type sat_coord(input logic signed [SAT_W-1:0] v);
      coord_type r;
      if (v > SAT_W'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (v < SAT_W'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rgpc_div.sv =====
// ============================================================================
// rgpc_div: restoring unsigned divider
// Produces one quotient bit per cycle; done rises together with the last quotient bit.
// ============================================================================
`default_nettype none

module rgpc_div #(
   parameter int NUM_W = 35,
   parameter int DEN_W = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Shift in next dividend bit and trial subtract
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/rgpc_dp.sv =====
// ============================================================================
// rgpc_dp: datapath for ray grid plane crossings
// Per-axis candidate distances, the exact radius test, the nearest-axis
// selection, two dividers for the off-axis coordinates and the result
// register. Executes one controller command per cycle.
// ============================================================================
`default_nettype none

module rgpc_dp #(
   parameter int MAX_RADIUS = rgpc_pkg::MAX_RADIUS_DEF,
   parameter int FRAC_BITS  = rgpc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rgpc_pkg::cmd_type                 cmd,
   output rgpc_pkg::stat_type                     stat,
   input  wire rgpc_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rgpc_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [rgpc_pkg::RADIUS_W-1:0]     csr_wdata
);

   localparam int POS_W  = rgpc_pkg::POS_W;
   localparam int DIR_W  = rgpc_pkg::DIR_W;
   localparam int DMAG_W = rgpc_pkg::DMAG_W;
   localparam int DSQ_W  = rgpc_pkg::DSQ_W;
   localparam int SAT_W  = rgpc_pkg::SAT_W;
   localparam int RAD_W  = rgpc_pkg::RADIUS_W;

   localparam int DK_W   = $clog2(((MAX_RADIUS + 1) << FRAC_BITS) + 1);
   localparam int RW     = $clog2(MAX_RADIUS + 1);
   localparam int RD_W   = RW + DMAG_W;
   localparam int LIM_W  = 2 * RD_W + 2 * FRAC_BITS;
   localparam int PRD_W  = 2 * DK_W + DSQ_W;
   localparam int CMP_W  = (LIM_W > PRD_W) ? LIM_W : PRD_W;
   localparam int PR_W   = DK_W + DMAG_W;
   localparam int NUM_W  = PR_W + 2;
   localparam int DEN_W  = DMAG_W + 1;
   localparam int PL_W   = (DK_W > POS_W) ? DK_W + 2 : POS_W + 2;
   localparam int OFF_W  = NUM_W + 2;

   localparam logic [DK_W-1:0] SCALE = DK_W'(1) << FRAC_BITS;

   // Ray and per-axis state
   logic signed [POS_W-1:0] pos_ff [3], pos_in [3];
   logic [DMAG_W-1:0]       dmag_ff [3], dmag_in [3];
   logic [2:0]              dneg_ff, dneg_in;
   logic [2:0]              active_ff, active_in;
   logic [2:0]              valid_ff, valid_in;
   logic [DK_W-1:0]         dk_ff [3], dk_in [3];
   logic [LIM_W-1:0]        lim_ff [3], lim_in [3];

   // Working registers
   logic [DSQ_W-1:0]        dsq_ff, dsq_in;
   logic [RAD_W-1:0]        radius_ff, radius_in;
   logic [RD_W-1:0]         rd_ff, rd_in;
   logic [2*DK_W-1:0]       dk2_ff, dk2_in;
   logic [DK_W+DSQ_W-1:0]   plo_ff, plo_in;
   logic [DK_W+DSQ_W-1:0]   phi_ff, phi_in;
   logic [PR_W-1:0]         pa_ff, pa_in;
   logic [PR_W-1:0]         pb_ff, pb_in;
   logic [1:0]              best_ff, best_in;
   logic                    bvalid_ff, bvalid_in;
   logic [PR_W-1:0]         num1_ff, num1_in;
   logic [PR_W-1:0]         num2_ff, num2_in;
   rgpc_pkg::coord_type     plane_ff, plane_in;
   rgpc_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Combinational helpers
   logic signed [POS_W-1:0] ld_pos [3];
   logic signed [DIR_W-1:0] ld_dir [3];
   logic [DMAG_W-1:0]       ld_mag [3];
   logic [FRAC_BITS-1:0]    ld_frac [3];
   logic [DK_W-1:0]         ld_dk0 [3];

   logic [1:0]              axis;
   logic [1:0]              b1;
   logic [1:0]              b2;
   logic [RW-1:0]           r_eff;
   logic [2*DMAG_W-1:0]     sq_prod;
   logic [RD_W-1:0]         rd_prod;
   logic [2*RD_W-1:0]       rd_sq;
   logic [2*DK_W-1:0]       dk_sq;
   logic [DK_W+DSQ_W-1:0]   lo_prod;
   logic [DK_W+DSQ_W-1:0]   hi_prod;
   logic [CMP_W-1:0]        prod_sum;
   logic [PR_W-1:0]         pa_prod;
   logic [PR_W-1:0]         pb_prod;
   logic [PR_W-1:0]         n1_prod;
   logic [PR_W-1:0]         n2_prod;
   logic signed [DK_W:0]    dk_best_s;
   logic signed [PL_W-1:0]  plane_sum;

   logic                    div_start;
   logic [NUM_W-1:0]        dvd1;
   logic [NUM_W-1:0]        dvd2;
   logic [DEN_W-1:0]        dvs;
   logic                    done1;
   logic                    done2;
   logic [NUM_W-1:0]        quo1;
   logic [NUM_W-1:0]        quo2;
   logic signed [OFF_W-1:0] q1_s;
   logic signed [OFF_W-1:0] q2_s;
   logic signed [OFF_W-1:0] off1;
   logic signed [OFF_W-1:0] off2;
   rgpc_pkg::coord_type     off1_sat;
   rgpc_pkg::coord_type     off2_sat;
   rgpc_pkg::coord_type     coord [3];

   // Unpack the incoming ray and find the first plane on each axis
   always_comb begin
      ld_pos[0] = req_data.pos_x;
      ld_pos[1] = req_data.pos_y;
      ld_pos[2] = req_data.pos_z;
      ld_dir[0] = req_data.dir_x;
      ld_dir[1] = req_data.dir_y;
      ld_dir[2] = req_data.dir_z;
      for (int i = 0; i < 3; i++) begin
         ld_frac[i] = ld_pos[i][FRAC_BITS-1:0];
         ld_mag[i]  = ld_dir[i][DIR_W-1] ? (DMAG_W'(~ld_dir[i]) + DMAG_W'(1))
                                         : DMAG_W'(ld_dir[i]);
         if (ld_dir[i][DIR_W-1]) begin
            ld_dk0[i] = DK_W'(ld_frac[i]);
         end else if (ld_frac[i] == '0) begin
            ld_dk0[i] = '0;
         end else begin
            ld_dk0[i] = SCALE - DK_W'(ld_frac[i]);
         end
      end
   end

   // Operand selection
   assign axis  = cmd.use_best ? best_ff : cmd.ax;
   assign b1    = rgpc_pkg::next_axis(best_ff);
   assign b2    = rgpc_pkg::prev_axis(best_ff);
   assign r_eff = (radius_ff > RAD_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_ff);

   // Multipliers, each feeding its own register
   assign sq_prod  = dmag_ff[axis] * dmag_ff[axis];
   assign rd_prod  = r_eff * dmag_ff[axis];
   assign rd_sq    = rd_ff * rd_ff;
   assign dk_sq    = dk_ff[axis] * dk_ff[axis];
   assign lo_prod  = dk2_ff[DK_W-1:0] * dsq_ff;
   assign hi_prod  = dk2_ff[2*DK_W-1:DK_W] * dsq_ff;
   assign prod_sum = (CMP_W'(phi_ff) << DK_W) + CMP_W'(plo_ff);
   assign pa_prod  = dk_ff[axis] * dmag_ff[best_ff];
   assign pb_prod  = dk_ff[best_ff] * dmag_ff[axis];
   assign n1_prod  = dk_ff[best_ff] * dmag_ff[b1];
   assign n2_prod  = dk_ff[best_ff] * dmag_ff[b2];

   // Crossed plane position: start point stepped by dk in the direction sign
   assign dk_best_s = $signed({1'b0, dk_ff[best_ff]});
   assign plane_sum = PL_W'(pos_ff[best_ff])
                    + (dneg_ff[best_ff] ? -PL_W'(dk_best_s) : PL_W'(dk_best_s));

   // Round-to-nearest division operands: (2|n| + den) / (2 den)
   assign div_start = (cmd.op == rgpc_pkg::OP_DIVGO);
   assign dvd1      = (NUM_W'(num1_ff) << 1) + NUM_W'(dmag_ff[best_ff]);
   assign dvd2      = (NUM_W'(num2_ff) << 1) + NUM_W'(dmag_ff[best_ff]);
   assign dvs       = DEN_W'(dmag_ff[best_ff]) << 1;

   rgpc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd1),
      .divisor  (dvs),
      .done     (done1),
      .quotient (quo1)
   );

   rgpc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div2 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd2),
      .divisor  (dvs),
      .done     (done2),
      .quotient (quo2)
   );

   // Off-axis coordinates, signed by their direction components
   assign q1_s     = OFF_W'(quo1);
   assign q2_s     = OFF_W'(quo2);
   assign off1     = OFF_W'(pos_ff[b1]) + (dneg_ff[b1] ? -q1_s : q1_s);
   assign off2     = OFF_W'(pos_ff[b2]) + (dneg_ff[b2] ? -q2_s : q2_s);
   assign off1_sat = rgpc_pkg::sat_coord(SAT_W'(off1));
   assign off2_sat = rgpc_pkg::sat_coord(SAT_W'(off2));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) == best_ff) begin
            coord[i] = plane_ff;
         end else if (2'(i) == b1) begin
            coord[i] = off1_sat;
         end else begin
            coord[i] = off2_sat;
         end
      end
   end

   // Command execution
   always_comb begin
      pos_in       = pos_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      active_in    = active_ff;
      valid_in     = valid_ff;
      dk_in        = dk_ff;
      lim_in       = lim_ff;
      dsq_in       = dsq_ff;
      rd_in        = rd_ff;
      dk2_in       = dk2_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      best_in      = best_ff;
      bvalid_in    = bvalid_ff;
      num1_in      = num1_ff;
      num2_in      = num2_ff;
      plane_in     = plane_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      radius_in    = csr_we ? csr_wdata : radius_ff;
      case (cmd.op)
         rgpc_pkg::OP_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i]    = ld_pos[i];
               dmag_in[i]   = ld_mag[i];
               dneg_in[i]   = ld_dir[i][DIR_W-1];
               active_in[i] = (ld_dir[i] != '0);
               dk_in[i]     = ld_dk0[i];
            end
            valid_in  = '0;
            bvalid_in = 1'b0;
            dsq_in    = '0;
         end
         rgpc_pkg::OP_SQ: begin
            dsq_in = dsq_ff + DSQ_W'(sq_prod);
         end
         rgpc_pkg::OP_LIM: begin
            rd_in = rd_prod;
         end
         rgpc_pkg::OP_LIM2: begin
            lim_in[axis] = LIM_W'(rd_sq) << (2 * FRAC_BITS);
         end
         rgpc_pkg::OP_DK2: begin
            dk2_in = dk_sq;
         end
         rgpc_pkg::OP_ML: begin
            plo_in = lo_prod;
         end
         rgpc_pkg::OP_MH: begin
            phi_in = hi_prod;
         end
         rgpc_pkg::OP_CMP: begin
            valid_in[axis] = active_ff[axis] && (prod_sum <= CMP_W'(lim_ff[axis]));
         end
         rgpc_pkg::OP_SELM: begin
            pa_in = pa_prod;
            pb_in = pb_prod;
         end
         rgpc_pkg::OP_SELC: begin
            // Keep the earlier axis on a tie
            if (valid_ff[axis] &&
                (axis == rgpc_pkg::AXIS_X || !bvalid_ff || pa_ff < pb_ff)) begin
               best_in   = axis;
               bvalid_in = 1'b1;
            end else if (axis == rgpc_pkg::AXIS_X) begin
               bvalid_in = 1'b0;
            end
         end
         rgpc_pkg::OP_NUM: begin
            num1_in  = n1_prod;
            num2_in  = n2_prod;
            plane_in = rgpc_pkg::sat_coord(SAT_W'(plane_sum));
         end
         rgpc_pkg::OP_ADV: begin
            dk_in[best_ff] = dk_ff[best_ff] + SCALE;
         end
         rgpc_pkg::OP_WRITE: begin
            rsp_in.hit_x      = coord[0];
            rsp_in.hit_y      = coord[1];
            rsp_in.hit_z      = coord[2];
            rsp_in.plane_axis = best_ff;
            rsp_in.last_hit   = ~(|valid_ff);
            rsp_valid_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control state cleared by reset, payload held
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         bvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= rgpc_pkg::RADIUS_RESET;
      end else begin
         valid_ff     <= valid_in;
         bvalid_ff    <= bvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
      end
      pos_ff    <= pos_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      active_ff <= active_in;
      dk_ff     <= dk_in;
      lim_ff    <= lim_in;
      dsq_ff    <= dsq_in;
      rd_ff     <= rd_in;
      dk2_ff    <= dk2_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      best_ff   <= best_in;
      num1_ff   <= num1_in;
      num2_ff   <= num2_in;
      plane_ff  <= plane_in;
      rsp_ff    <= rsp_in;
   end

   // Status back to the controller
   assign stat.any_valid = |valid_ff;
   assign stat.div_done  = done1 & done2;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result is written only with a selected axis
   a_write_has_best: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rgpc_pkg::OP_WRITE |-> bvalid_ff)
      else $error("result written without a selected axis");

   // A result never overwrites one still waiting
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rgpc_pkg::OP_WRITE |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // Divider status drops right after a start
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rgpc_pkg::OP_DIVGO |=> !(done1 || done2))
      else $error("divider done flag stale after start");

endmodule

`default_nettype wire

// ===== rtl/rgpc_ctrl.sv =====
// ============================================================================
// rgpc_ctrl: sequencer for ray grid plane crossings
// Steps the datapath through ray setup, the per-axis radius tests, the
// nearest-axis selection, the coordinate divisions and the result writes.
// ============================================================================
`default_nettype none

module rgpc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire rgpc_pkg::stat_type  stat,
   output rgpc_pkg::cmd_type        cmd
);

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_SQ    = 15'b000000000000010,
      S_LIM   = 15'b000000000000100,
      S_LIM2  = 15'b000000000001000,
      S_DK2   = 15'b000000000010000,
      S_ML    = 15'b000000000100000,
      S_MH    = 15'b000000001000000,
      S_CMP   = 15'b000000010000000,
      S_SELM  = 15'b000000100000000,
      S_SELC  = 15'b000001000000000,
      S_NUM   = 15'b000010000000000,
      S_DIV   = 15'b000100000000000,
      S_WAIT  = 15'b001000000000000,
      S_ADV   = 15'b010000000000000,
      S_WRITE = 15'b100000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic       init_ff, init_in;

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      init_in      = init_ff;
      cmd.op       = rgpc_pkg::OP_NONE;
      cmd.ax       = ax_ff;
      cmd.use_best = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Take a new ray
            if (req_valid) begin
               cmd.op   = rgpc_pkg::OP_LOAD;
               ax_in    = rgpc_pkg::AXIS_X;
               init_in  = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            // Accumulate the squared direction length
            cmd.op = rgpc_pkg::OP_SQ;
            if (ax_ff == rgpc_pkg::AXIS_Z) begin
               ax_in    = rgpc_pkg::AXIS_X;
               state_in = S_LIM;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_LIM: begin
            cmd.op   = rgpc_pkg::OP_LIM;
            state_in = S_LIM2;
         end
         S_LIM2: begin
            cmd.op   = rgpc_pkg::OP_LIM2;
            state_in = S_DK2;
         end
         S_DK2: begin
            cmd.op       = rgpc_pkg::OP_DK2;
            cmd.use_best = !init_ff;
            state_in     = S_ML;
         end
         S_ML: begin
            cmd.op   = rgpc_pkg::OP_ML;
            state_in = S_MH;
         end
         S_MH: begin
            cmd.op   = rgpc_pkg::OP_MH;
            state_in = S_CMP;
         end
         S_CMP: begin
            // Radius test; walk all axes at setup, only the stepped axis later
            cmd.op       = rgpc_pkg::OP_CMP;
            cmd.use_best = !init_ff;
            if (!init_ff) begin
               state_in = S_WRITE;
            end else if (ax_ff == rgpc_pkg::AXIS_Z) begin
               ax_in    = rgpc_pkg::AXIS_X;
               init_in  = 1'b0;
               state_in = S_SELM;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_LIM;
            end
         end
         S_SELM: begin
            cmd.op   = rgpc_pkg::OP_SELM;
            state_in = S_SELC;
         end
         S_SELC: begin
            // Pick the nearest candidate; drop the ray if none is in range
            cmd.op = rgpc_pkg::OP_SELC;
            if (ax_ff == rgpc_pkg::AXIS_Z) begin
               ax_in    = rgpc_pkg::AXIS_X;
               state_in = stat.any_valid ? S_NUM : S_IDLE;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_SELM;
            end
         end
         S_NUM: begin
            cmd.op   = rgpc_pkg::OP_NUM;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op   = rgpc_pkg::OP_DIVGO;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (stat.div_done) begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            // Advance the chosen axis to its next plane
            cmd.op   = rgpc_pkg::OP_ADV;
            state_in = S_DK2;
         end
         S_WRITE: begin
            // Hold until the result register is free
            if (stat.out_free) begin
               cmd.op   = rgpc_pkg::OP_WRITE;
               ax_in    = rgpc_pkg::AXIS_X;
               state_in = stat.any_valid ? S_SELM : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= rgpc_pkg::AXIS_X;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         init_ff  <= init_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ray_grid_plane_crossings.sv =====
// One ray at a time: a new ray is taken only while the controller is idle.
// The restoring dividers, NUM_W = 35 at default widths, produce one quotient bit per
// cycle for the two off-axis coordinates.
// Reset (synchronous, active high): radius returns to 8, controller to idle,
// result register empty.
// ============================================================================
// ray_grid_plane_crossings: ray to integer grid plane crossing enumerator
// Emits every x, y or z plane crossing of a ray within the configured
// radius, nearest first, ties ordered x, y, z.
// ============================================================================
`default_nettype none

module ray_grid_plane_crossings #(
   parameter int MAX_RADIUS = rgpc_pkg::MAX_RADIUS_DEF,
   parameter int FRAC_BITS  = rgpc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire rgpc_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output rgpc_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [rgpc_pkg::RADIUS_W-1:0]  csr_wdata
);

   rgpc_pkg::cmd_type  cmd;
   rgpc_pkg::stat_type stat;

   rgpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rgpc_dp #(
      .MAX_RADIUS (MAX_RADIUS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire
